@@ design/ctm_pkg.sv @@
// Shared types, constants and helper functions for the chord template matcher.
// Used by the controller, the datapath and the top level; depends on nothing.

package ctm_pkg;

    localparam int PC_COUNT       = 12;
    localparam int TEMPLATE_COUNT = 25;

    localparam logic [3:0] LAST_ROOT     = 4'd11;
    localparam logic [4:0] LAST_TEMPLATE = 5'd24;
    localparam logic [3:0] MIN_NOTES     = 4'd2;
    localparam logic signed [7:0] VALID_SCORE = 8'sd10;
    localparam logic [8:0] FULL_BONUS    = 9'd5;

    // Chord shapes as pitch-class masks with the root on bit 0, in table order.
    localparam logic [11:0] TEMPLATE_MASKS [TEMPLATE_COUNT] = '{
        12'h091, 12'h089, 12'h049, 12'h111, 12'h085, 12'h0A1, 12'h081,
        12'h891, 12'h491, 12'h489, 12'h889, 12'h249, 12'h449, 12'h511,
        12'h291, 12'h289,
        12'h895, 12'h495, 12'h48D, 12'h095, 12'h08D,
        12'h4B5, 12'h8B5, 12'h6B5, 12'hAB5
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } ctm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_pair;
    } ctm_stat_t;

    function automatic logic [3:0] count_ones(input logic [11:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < PC_COUNT; i++) begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction

    function automatic logic [11:0] rotate_up(input logic [11:0] m, input logic [3:0] r);
        logic [23:0] w;
        w = {m, m} << r;
        return w[23:12];
    endfunction

endpackage

@@ design/chord_template_matcher.sv @@
// Chord template matcher: after a word is accepted, all 300 (root, template) pairs are scored,
// one pair per cycle on the shared scorer, then a commit step writes the result, waiting while
// the previous result is still stalled in the output register.
// Input is stalled while scanning and committing, so no new word is taken before the last one
// is committed; the next word is taken in the idle cycle after commit.
// Reset (rst_n, asynchronous, active low) returns to idle with no output word pending.

module chord_template_matcher (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [11:0]       pitch_mask,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              chord_valid,
    output logic [3:0]        root_class,
    output logic [4:0]        quality_index,
    output logic signed [7:0] best_score
);

    ctm_pkg::ctm_cmd_t  cmd;
    ctm_pkg::ctm_stat_t stat;

    ctm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ctm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .pitch_mask    (pitch_mask),
        .chord_valid   (chord_valid),
        .root_class    (root_class),
        .quality_index (quality_index),
        .best_score    (best_score)
    );

endmodule

@@ design/ctm_ctrl.sv @@
// Controller state machine for the chord template matcher.
// Issues load, step and commit commands; depends on ctm_pkg.

module ctm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  ctm_pkg::ctm_stat_t stat,
    output ctm_pkg::ctm_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   slot_free;

    // The output register can take a new word if empty or being emptied now.
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd.load   = (state_reg == ST_IDLE) && in_valid;
        cmd.step   = (state_reg == ST_SCAN);
        cmd.commit = (state_reg == ST_COMMIT) && slot_free;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (stat.last_pair)
                    begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/ctm_datapath.sv @@
// Datapath of the chord template matcher: one shared pair scorer, the
// root and template counters, the running best and the output register. Depends on ctm_pkg.

module ctm_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ctm_pkg::ctm_cmd_t  cmd,
    output ctm_pkg::ctm_stat_t stat,
    input  logic [11:0]        pitch_mask,
    output logic               chord_valid,
    output logic [3:0]         root_class,
    output logic [4:0]         quality_index,
    output logic signed [7:0]  best_score
);

    logic [11:0]       notes_reg;
    logic [3:0]        note_count_reg;
    logic [3:0]        root_reg;
    logic [4:0]        tmpl_reg;
    logic              first_reg;
    logic signed [7:0] best_reg;
    logic [3:0]        best_root_reg;
    logic [4:0]        best_tmpl_reg;

    logic              chord_valid_reg;
    logic [3:0]        root_class_reg;
    logic [4:0]        quality_index_reg;
    logic signed [7:0] best_score_reg;

    logic [11:0]       tmpl_mask;
    logic [3:0]        hits;
    logic [3:0]        tmpl_count;
    logic [3:0]        missing;
    logic [3:0]        extra;
    logic [4:0]        penalty_count;
    logic [8:0]        gain;
    logic [8:0]        cost;
    logic [8:0]        bonus;
    logic signed [8:0] score;
    logic              take;

    // Score the current (root, template) pair.
    always_comb
    begin
        tmpl_mask     = ctm_pkg::rotate_up(ctm_pkg::TEMPLATE_MASKS[tmpl_reg], root_reg);
        hits          = ctm_pkg::count_ones(notes_reg & tmpl_mask);
        tmpl_count    = ctm_pkg::count_ones(tmpl_mask);
        missing       = tmpl_count - hits;
        extra         = note_count_reg - hits;
        penalty_count = {1'b0, missing} + {1'b0, extra};
        gain          = {2'b00, hits, 3'b000} + {4'b0000, hits, 1'b0};
        cost          = {2'b00, penalty_count, 2'b00};
        bonus         = (missing == 4'd0) ? ctm_pkg::FULL_BONUS : 9'd0;
        score         = $signed(gain - cost + bonus);
        take          = first_reg || (score > $signed({best_reg[7], best_reg}));
    end

    assign stat.last_pair = (root_reg == ctm_pkg::LAST_ROOT) &&
                            (tmpl_reg == ctm_pkg::LAST_TEMPLATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg  <= 4'd0;
            tmpl_reg  <= 5'd0;
            first_reg <= 1'b1;
        end
        else
        begin
            if (cmd.load)
            begin
                root_reg  <= 4'd0;
                tmpl_reg  <= 5'd0;
                first_reg <= 1'b1;
            end
            else if (cmd.step)
            begin
                first_reg <= 1'b0;
                if (tmpl_reg == ctm_pkg::LAST_TEMPLATE)
                begin
                    tmpl_reg <= 5'd0;
                    root_reg <= root_reg + 4'd1;
                end
                else
                begin
                    tmpl_reg <= tmpl_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            notes_reg      <= pitch_mask;
            note_count_reg <= ctm_pkg::count_ones(pitch_mask);
        end
        if (cmd.step && take)
        begin
            best_reg      <= score[7:0];
            best_root_reg <= root_reg;
            best_tmpl_reg <= tmpl_reg;
        end
        if (cmd.commit)
        begin
            // Fewer than two notes gives an all-zero word.
            if (note_count_reg < ctm_pkg::MIN_NOTES)
            begin
                chord_valid_reg   <= 1'b0;
                root_class_reg    <= 4'd0;
                quality_index_reg <= 5'd0;
                best_score_reg    <= 8'sd0;
            end
            else
            begin
                chord_valid_reg   <= (best_reg >= ctm_pkg::VALID_SCORE);
                root_class_reg    <= best_root_reg;
                quality_index_reg <= best_tmpl_reg;
                best_score_reg    <= best_reg;
            end
        end
    end

    assign chord_valid   = chord_valid_reg;
    assign root_class    = root_class_reg;
    assign quality_index = quality_index_reg;
    assign best_score    = best_score_reg;

endmodule

@@ design/ctm_checker.sv @@
// Port-level checker for the chord template matcher, bound to the top level.
// Depends only on the top level's ports.

module ctm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [11:0]       pitch_mask,
    input logic              out_valid,
    input logic              out_stall,
    input logic              chord_valid,
    input logic [3:0]        root_class,
    input logic [4:0]        quality_index,
    input logic signed [7:0] best_score
);

    // A stalled output word stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(chord_valid) && $stable(root_class) &&
            $stable(quality_index) && $stable(best_score))
        else $error("output word changed while stalled");

    // Once a word is taken the block is busy scanning.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again straight after acceptance");

    // A valid chord carries a score of at least ten.
    a_valid_score: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chord_valid |-> best_score >= 8'sd10)
        else $error("chord flagged valid with a low score");

    // Root and template index stay within their tables.
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (root_class <= 4'd11) && (quality_index <= 5'd24))
        else $error("root or template index out of range");

endmodule

bind chord_template_matcher ctm_checker u_ctm_checker (.*);

@@ verif/chord_template_matcher_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for chord_template_matcher: directed and random pitch-class words,
// predicted by an independent chord scorer and checked by a small scoreboard class.
// Depends only on the chord_template_matcher RTL.

localparam int NOTE_CLASSES   = 12;
localparam int SHAPE_COUNT    = 25;
localparam int HIT_POINTS     = 10;
localparam int MISS_PENALTY   = 4;
localparam int COMPLETE_BONUS = 5;
localparam int FEWEST_NOTES   = 2;
localparam int CHORD_THRESHOLD = 10;

// Chord shapes with the root on bit 0, in quality-index order (major first, major 13th last).
localparam logic [11:0] CHORD_SHAPES [SHAPE_COUNT] = '{
    12'h091, 12'h089, 12'h049, 12'h111, 12'h085, 12'h0A1, 12'h081,
    12'h891, 12'h491, 12'h489, 12'h889, 12'h249, 12'h449, 12'h511,
    12'h291, 12'h289,
    12'h895, 12'h495, 12'h48D, 12'h095, 12'h08D,
    12'h4B5, 12'h8B5, 12'h6B5, 12'hAB5
};

typedef struct packed {
    logic              chord_valid;
    logic [3:0]        root_class;
    logic [4:0]        quality_index;
    logic signed [7:0] best_score;
} chord_result_t;

function automatic logic [11:0] transpose_shape(input logic [11:0] shape, input int root);
    logic [11:0] up;
    logic [11:0] wrapped;
    up = shape << root;
    wrapped = shape >> (NOTE_CLASSES - root);
    return up | wrapped;
endfunction

class chord_scoreboard;
    chord_result_t awaited[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    // Scans roots outermost and shapes innermost; only a strictly higher score displaces the leader.
    static function chord_result_t score_chord(input logic [11:0] notes);
        chord_result_t res;
        logic [11:0] shape;
        int best;
        int pts;
        int hits;
        int missing;
        int extra;
        bit have;
        res = '0;
        best = 0;
        have = 0;
        if ($countones(notes) < FEWEST_NOTES)
            return res;
        for (int r = 0; r < NOTE_CLASSES; r++)
        begin
            for (int t = 0; t < SHAPE_COUNT; t++)
            begin
                shape = transpose_shape(CHORD_SHAPES[t], r);
                hits = $countones(notes & shape);
                missing = $countones(shape & ~notes);
                extra = $countones(notes & ~shape);
                pts = hits * HIT_POINTS - (missing + extra) * MISS_PENALTY;
                if (missing == 0)
                    pts = pts + COMPLETE_BONUS;
                if (!have || pts > best)
                begin
                    have = 1;
                    best = pts;
                    res.root_class = r[3:0];
                    res.quality_index = t[4:0];
                end
            end
        end
        res.best_score = best[7:0];
        res.chord_valid = (best >= CHORD_THRESHOLD);
        return res;
    endfunction

    function void note_word(input logic [11:0] notes);
        awaited.push_back(score_chord(notes));
    endfunction

    function void check_word(input chord_result_t got);
        chord_result_t want;
        if (awaited.size() == 0)
        begin
            $display("%0t: result word with nothing awaited: valid %0b root %0d quality %0d score %0d",
                     $time, got.chord_valid, got.root_class, got.quality_index, got.best_score);
            errors++;
            return;
        end
        want = awaited.pop_front();
        if (got.chord_valid !== want.chord_valid)
        begin
            $display("%0t: chord_valid expected %0b actual %0b",
                     $time, want.chord_valid, got.chord_valid);
            errors++;
        end
        if (got.root_class !== want.root_class)
        begin
            $display("%0t: root_class expected %0d actual %0d",
                     $time, want.root_class, got.root_class);
            errors++;
        end
        if (got.quality_index !== want.quality_index)
        begin
            $display("%0t: quality_index expected %0d actual %0d",
                     $time, want.quality_index, got.quality_index);
            errors++;
        end
        if (got.best_score !== want.best_score)
        begin
            $display("%0t: best_score expected %0d actual %0d",
                     $time, want.best_score, got.best_score);
            errors++;
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction
endclass

module chord_template_matcher_test;

    localparam int RANDOM_WORDS   = 550;
    localparam int DRAIN_CYCLES   = 320;
    localparam int WATCHDOG_LIMIT = 4000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [11:0]       pitch_mask;
    logic              out_valid;
    logic              out_stall;
    logic              chord_valid;
    logic [3:0]        root_class;
    logic [4:0]        quality_index;
    logic signed [7:0] best_score;

    chord_scoreboard board;
    bit quiet;
    int stall_run;
    int idle_cycles;

    chord_template_matcher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pitch_mask    (pitch_mask),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .chord_valid   (chord_valid),
        .root_class    (root_class),
        .quality_index (quality_index),
        .best_score    (best_score)
    );

    always #1 clk = ~clk;

    // Mostly short idle spells, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 24);
        return $urandom_range(60, 500);
    endfunction

    task automatic send_word(input logic [11:0] notes);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pitch_mask <= notes;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_word(pitch_mask);
            if (out_valid && !out_stall)
                board.check_word({chord_valid, root_class, quality_index, best_score});
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || quiet)
        begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run != 0)
            stall_run <= stall_run - 1;
        else
        begin
            out_stall <= ($urandom_range(0, 1) == 1);
            stall_run <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [11:0] notes;
        logic [11:0] flips;
        int a;
        int b;
        board = new();
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        pitch_mask <= 12'h000;
        quiet <= 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty set, a lone note, every pitch class, and a two-note cluster a semitone apart.
        send_word(12'h000);
        send_word(12'h400);
        send_word(12'hFFF);
        send_word(12'h801);
        // Every chord shape once, on roots spread round the octave.
        for (int t = 0; t < SHAPE_COUNT; t++)
            send_word(transpose_shape(CHORD_SHAPES[t], (t * 5) % NOTE_CLASSES));

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 50 == 0)
                quiet <= ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    // A real chord, sometimes with a note added or dropped.
                    flips = 12'h000;
                    if ($urandom_range(0, 2) != 0)
                        flips[$urandom_range(0, 11)] = 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        flips[$urandom_range(0, 11)] = 1'b1;
                    notes = transpose_shape(CHORD_SHAPES[$urandom_range(0, SHAPE_COUNT - 1)],
                                            $urandom_range(0, NOTE_CLASSES - 1)) ^ flips;
                end
                5, 6, 7:
                    notes = 12'($urandom_range(0, 4095));
                8:
                begin
                    a = $urandom_range(0, 11);
                    b = $urandom_range(0, 11);
                    notes = 12'h000;
                    notes[a] = 1'b1;
                    notes[b] = 1'b1;
                end
                default:
                begin
                    notes = 12'hFFF;
                    notes[$urandom_range(0, 11)] = 1'b0;
                    notes[$urandom_range(0, 11)] = 1'b0;
                end
            endcase
            send_word(notes);
        end
        in_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
